FILE: rtl/tiu_pkg.sv
// time interval unit package: operation codes, urgency codes, interval and result types
// no dependencies; used by tiu_alu and time_interval_unit
`timescale 1ns / 1ps
`default_nettype none

package tiu_pkg;

    localparam int TIME_W = 64;

    localparam logic [TIME_W-1:0] TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};
    localparam logic [TIME_W-1:0] TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};
    localparam logic [TIME_W-1:0] TIME_ZERO = '0;
    localparam logic [TIME_W-1:0] TIME_ONE = {{(TIME_W-1){1'b0}}, 1'b1};

    typedef enum logic [3:0] {
        FN_EMPTY     = 4'd0,
        FN_MEMBER    = 4'd1,
        FN_SIZE      = 4'd2,
        FN_NEXT      = 4'd3,
        FN_URGENT    = 4'd4,
        FN_WAIT      = 4'd5,
        FN_INTERSECT = 4'd6,
        FN_ADD       = 4'd7,
        FN_SUB       = 4'd8,
        FN_NEGATE    = 4'd9
    } func_t;

    typedef enum logic [1:0] {
        URG_LAZY      = 2'd0,
        URG_DELAYABLE = 2'd1,
        URG_EAGER     = 2'd2
    } urgency_t;

    typedef struct packed {
        logic [TIME_W-1:0] lo;
        logic [TIME_W-1:0] hi;
        logic              lo_open;
        logic              hi_open;
    } ival_t;

    typedef struct packed {
        ival_t             ival;
        logic              flag;
        logic [TIME_W-1:0] tval;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/tiu_alu.sv
// time interval unit operation logic: one interval operation, purely combinational
// depends on tiu_pkg
`timescale 1ns / 1ps
`default_nettype none

module tiu_alu (
    input  wire logic [3:0]                   func,
    input  wire tiu_pkg::ival_t               a,
    input  wire tiu_pkg::ival_t               b,
    input  wire logic [tiu_pkg::TIME_W-1:0]   time_point,
    input  wire logic [1:0]                   urgency_kind,
    output tiu_pkg::result_t                  result
);

    function automatic logic lt(input logic [tiu_pkg::TIME_W-1:0] x,
                                input logic [tiu_pkg::TIME_W-1:0] y);
        return $signed(x) < $signed(y);
    endfunction

    function automatic logic is_empty(input tiu_pkg::ival_t x);
        return lt(x.hi, x.lo) || (x.lo == x.hi && (x.lo_open || x.hi_open));
    endfunction

    function automatic logic contains(input tiu_pkg::ival_t x,
                                      input logic [tiu_pkg::TIME_W-1:0] t);
        return (lt(x.lo, t) || (x.lo == t && !x.lo_open)) &&
               (lt(t, x.hi) || (t == x.hi && !x.hi_open));
    endfunction

    function automatic logic [tiu_pkg::TIME_W-1:0] sat_add(
        input logic [tiu_pkg::TIME_W-1:0] x,
        input logic [tiu_pkg::TIME_W-1:0] y);
        logic [tiu_pkg::TIME_W:0] s;
        s = {x[tiu_pkg::TIME_W-1], x} + {y[tiu_pkg::TIME_W-1], y};
        if (s[tiu_pkg::TIME_W] != s[tiu_pkg::TIME_W-1]) begin
            return s[tiu_pkg::TIME_W] ? tiu_pkg::TIME_MIN : tiu_pkg::TIME_MAX;
        end
        return s[tiu_pkg::TIME_W-1:0];
    endfunction

    function automatic logic [tiu_pkg::TIME_W-1:0] sat_sub(
        input logic [tiu_pkg::TIME_W-1:0] x,
        input logic [tiu_pkg::TIME_W-1:0] y);
        logic [tiu_pkg::TIME_W:0] s;
        s = {x[tiu_pkg::TIME_W-1], x} - {y[tiu_pkg::TIME_W-1], y};
        if (s[tiu_pkg::TIME_W] != s[tiu_pkg::TIME_W-1]) begin
            return s[tiu_pkg::TIME_W] ? tiu_pkg::TIME_MIN : tiu_pkg::TIME_MAX;
        end
        return s[tiu_pkg::TIME_W-1:0];
    endfunction

    function automatic logic [tiu_pkg::TIME_W-1:0] sat_neg(
        input logic [tiu_pkg::TIME_W-1:0] x);
        if (x == tiu_pkg::TIME_MIN) begin
            return tiu_pkg::TIME_MAX;
        end
        return tiu_pkg::TIME_ZERO - x;
    endfunction

    tiu_pkg::ival_t            none_ival;
    tiu_pkg::ival_t            urgent_ival;
    tiu_pkg::ival_t            wait_ival;
    tiu_pkg::ival_t            meet_ival;
    logic                      a_empty;
    logic                      a_has_t;
    logic [tiu_pkg::TIME_W-1:0] diff;
    logic [tiu_pkg::TIME_W-1:0] size_val;
    logic [tiu_pkg::TIME_W-1:0] next_val;
    logic [tiu_pkg::TIME_W-1:0] lo_plus;

    assign none_ival = '{lo: tiu_pkg::TIME_MAX, hi: tiu_pkg::TIME_MIN,
                         lo_open: 1'b0, hi_open: 1'b0};
    assign a_empty = is_empty(a);
    assign a_has_t = contains(a, time_point);

    // size: unsigned difference, saturated
    assign diff = a.hi - a.lo;
    always_comb begin
        if (a_empty) begin
            size_val = tiu_pkg::TIME_ZERO;
        end else if (diff[tiu_pkg::TIME_W-1]) begin
            size_val = tiu_pkg::TIME_MAX;
        end else begin
            size_val = diff;
        end
    end

    // next reachable time; non-empty open left end means lo < hi
    assign lo_plus = a.lo + tiu_pkg::TIME_ONE;
    always_comb begin
        if (a_empty) begin
            next_val = tiu_pkg::TIME_MAX;
        end else if (a_has_t) begin
            next_val = time_point;
        end else if (!lt(a.lo, time_point)) begin
            if (!a.lo_open) begin
                next_val = a.lo;
            end else if (lt(lo_plus, a.hi) || (lo_plus == a.hi && !a.hi_open)) begin
                next_val = lo_plus;
            end else begin
                next_val = tiu_pkg::TIME_MAX;
            end
        end else begin
            next_val = tiu_pkg::TIME_MAX;
        end
    end

    // urgency restriction
    always_comb begin
        urgent_ival = none_ival;
        if (!a_empty) begin
            case (urgency_kind)
                tiu_pkg::URG_DELAYABLE: begin
                    if (a.hi != tiu_pkg::TIME_MAX && !a.hi_open) begin
                        urgent_ival = '{lo: a.hi, hi: a.hi, lo_open: 1'b0, hi_open: 1'b0};
                    end
                end
                tiu_pkg::URG_EAGER: begin
                    urgent_ival = a;
                end
                default: begin
                    urgent_ival = none_ival;
                end
            endcase
        end
    end

    // wait window from the urgent set
    always_comb begin
        wait_ival = '{lo: time_point, hi: tiu_pkg::TIME_MAX, lo_open: 1'b0, hi_open: 1'b0};
        if (!a_empty && urgency_kind == tiu_pkg::URG_DELAYABLE) begin
            if (a.hi != tiu_pkg::TIME_MAX && !a.hi_open && !lt(a.hi, time_point)) begin
                wait_ival.hi = a.hi;
            end
        end else if (!a_empty && urgency_kind == tiu_pkg::URG_EAGER) begin
            if (!lt(a.lo, time_point)) begin
                wait_ival.hi = a.lo;
            end else if (a_has_t) begin
                wait_ival.hi = time_point;
            end
        end
    end

    // intersection: tighter bound on each end
    always_comb begin
        meet_ival = a;
        if (lt(a.lo, b.lo) || (a.lo == b.lo && !a.lo_open)) begin
            meet_ival.lo = b.lo;
            meet_ival.lo_open = b.lo_open;
        end
        if (lt(b.hi, a.hi) || (a.hi == b.hi && !a.hi_open)) begin
            meet_ival.hi = b.hi;
            meet_ival.hi_open = b.hi_open;
        end
    end

    always_comb begin
        result = '0;
        case (func)
            tiu_pkg::FN_EMPTY:     result.flag = a_empty;
            tiu_pkg::FN_MEMBER:    result.flag = a_has_t;
            tiu_pkg::FN_SIZE:      result.tval = size_val;
            tiu_pkg::FN_NEXT:      result.tval = next_val;
            tiu_pkg::FN_URGENT:    result.ival = urgent_ival;
            tiu_pkg::FN_WAIT:      result.ival = wait_ival;
            tiu_pkg::FN_INTERSECT: result.ival = meet_ival;
            tiu_pkg::FN_ADD: begin
                result.ival = '{lo: sat_add(a.lo, time_point), hi: sat_add(a.hi, time_point),
                                lo_open: a.lo_open, hi_open: a.hi_open};
            end
            tiu_pkg::FN_SUB: begin
                result.ival = '{lo: sat_sub(a.lo, time_point), hi: sat_sub(a.hi, time_point),
                                lo_open: a.lo_open, hi_open: a.hi_open};
            end
            tiu_pkg::FN_NEGATE: begin
                result.ival = '{lo: sat_neg(a.hi), hi: sat_neg(a.lo),
                                lo_open: a.hi_open, hi_open: a.lo_open};
            end
            default: result = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/time_interval_unit.sv
// Time interval unit: one interval operation per item on signed 64-bit nanosecond
// endpoints with open flags. Each item is latched in an input register, evaluated by
// one pass of compare/add logic and latched in a result register. A new item is
// accepted every cycle while m_ready is high or the result register is empty; the
// result register holds a finished item while the next one waits in the input register.
// Depends on tiu_pkg and tiu_alu.
`timescale 1ns / 1ps
`default_nettype none

module time_interval_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [3:0]  s_func,
    input  wire logic [63:0] s_a_left,
    input  wire logic [63:0] s_a_right,
    input  wire logic        s_a_left_open,
    input  wire logic        s_a_right_open,
    input  wire logic [63:0] s_b_left,
    input  wire logic [63:0] s_b_right,
    input  wire logic        s_b_left_open,
    input  wire logic        s_b_right_open,
    input  wire logic [63:0] s_time_point,
    input  wire logic [1:0]  s_urgency_kind,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_out_left,
    output logic [63:0]      m_out_right,
    output logic             m_out_left_open,
    output logic             m_out_right_open,
    output logic             m_out_flag,
    output logic [63:0]      m_out_time
);

    logic             in_valid_reg;
    logic [3:0]       func_reg;
    tiu_pkg::ival_t   a_reg;
    tiu_pkg::ival_t   b_reg;
    logic [63:0]      time_reg;
    logic [1:0]       urgency_reg;
    logic             out_valid_reg;
    tiu_pkg::result_t result_reg;
    tiu_pkg::result_t result_next;
    logic             advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            func_reg <= s_func;
            a_reg <= '{lo: s_a_left, hi: s_a_right,
                       lo_open: s_a_left_open, hi_open: s_a_right_open};
            b_reg <= '{lo: s_b_left, hi: s_b_right,
                       lo_open: s_b_left_open, hi_open: s_b_right_open};
            time_reg <= s_time_point;
            urgency_reg <= s_urgency_kind;
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

    tiu_alu u_alu (
        .func         (func_reg),
        .a            (a_reg),
        .b            (b_reg),
        .time_point   (time_reg),
        .urgency_kind (urgency_reg),
        .result       (result_next)
    );

    assign m_valid = out_valid_reg;
    assign m_out_left = result_reg.ival.lo;
    assign m_out_right = result_reg.ival.hi;
    assign m_out_left_open = result_reg.ival.lo_open;
    assign m_out_right_open = result_reg.ival.hi_open;
    assign m_out_flag = result_reg.flag;
    assign m_out_time = result_reg.tval;

endmodule

`default_nettype wire
